/* rtl/qau_pkg.sv */
// Shared types, constants and helper functions of the quaternion arithmetic unit.
package qau_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned OpW   = 3;
    localparam int unsigned FracW = 16;

    typedef enum logic [OpW-1:0] {
        OP_MUL  = 3'd0,
        OP_ROT  = 3'd1,
        OP_CONJ = 3'd2,
        OP_NORM = 3'd3,
        OP_DOT  = 3'd4,
        OP_FWD  = 3'd5
    } t_op;

    typedef logic signed [DataW-1:0] t_q;
    typedef logic signed [DataW:0]   t_q33;   // 33-bit intermediates (2*x, sums)
    typedef logic signed [DataW+19:0] t_acc;  // sums of truncated 32x32 products, doubled

    localparam t_q   QMax = {1'b0, {(DataW-1){1'b1}}};
    localparam t_q   QMin = {1'b1, {(DataW-1){1'b0}}};
    localparam t_acc OneQ = t_acc'(1) <<< FracW;

    // Exact product of two 33-bit signed values, truncated toward minus infinity.
    function automatic t_acc mq(input t_q33 a, input t_q33 b);
        logic signed [2*DataW+1:0] p;
        begin
            p  = a * b;
            mq = t_acc'(p >>> FracW);
        end
    endfunction

    // Saturate a wide sum to 32 bits, reporting a clip.
    function automatic t_q sat(input t_acc v, output logic clip);
        begin
            if (v > t_acc'(QMax)) begin
                sat  = QMax;
                clip = 1'b1;
            end else if (v < t_acc'(QMin)) begin
                sat  = QMin;
                clip = 1'b1;
            end else begin
                sat  = t_q'(v);
                clip = 1'b0;
            end
        end
    endfunction

endpackage

/* rtl/qau_norm.sv */
// Pipelined square root and division for the normalize operation.
module qau_norm
    import qau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_sum,     // low 64 bits of the sum of squares
    input  logic        i_ovf,     // sum reached 2^64
    input  t_q          i_a [4],
    output t_q          o_r [4],
    output logic        o_clip,
    output logic        o_zero
);
    // Sqrt: 32 stages of one result bit each, then division: 4 lanes of 49 stages.
    localparam int unsigned SqN  = 32;
    localparam int unsigned DivN = 49;
    localparam int unsigned LenW = 33;

    // square root stage registers
    logic [63:0]     r_srem [SqN+1];
    logic [LenW-1:0] r_sres [SqN+1];
    logic            r_sovf [SqN+1];
    t_q              r_sa   [SqN+1][4];

    always_comb begin
        r_srem[0] = i_sum;
        r_sres[0] = '0;
        r_sovf[0] = i_ovf;
        r_sa[0]   = i_a;
    end

    for (genvar s = 0; s < SqN; s++) begin : g_sq
        logic [65:0] trial;
        logic [65:0] rem_ext;
        assign rem_ext = {2'b00, r_srem[s]};
        assign trial   = ({33'd0, r_sres[s]} << (2*(SqN-1-s)+2))
                       | (66'd1 << (2*(SqN-1-s)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sovf[s+1] <= r_sovf[s];
                r_sa[s+1]   <= r_sa[s];
                if (rem_ext >= trial) begin
                    r_srem[s+1] <= 64'(rem_ext - trial);
                    r_sres[s+1] <= (r_sres[s] << 1) | LenW'(1);
                end else begin
                    r_srem[s+1] <= r_srem[s];
                    r_sres[s+1] <= r_sres[s] << 1;
                end
            end
        end
    end

    // divider: magnitude restoring division of |a|<<16 by L
    logic [48:0]     r_num  [DivN+1][4];
    logic [LenW:0]   r_rem  [DivN+1][4];
    logic            r_neg  [DivN+1][4];
    logic [LenW-1:0] r_len  [DivN+1];

    always_comb begin
        r_len[0] = r_sovf[SqN] ? (LenW'(1) << 32) : r_sres[SqN];
        for (int k = 0; k < 4; k++) begin
            r_neg[0][k] = r_sa[SqN][k][DataW-1];
            r_num[0][k] = {(r_sa[SqN][k][DataW-1] ? -{1'b1, r_sa[SqN][k]}
                                                  : {1'b0, r_sa[SqN][k]}), 16'd0};
            r_rem[0][k] = '0;
        end
    end

    for (genvar s = 0; s < DivN; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len[s+1] <= r_len[s];
                for (int k = 0; k < 4; k++) begin
                    logic [LenW+1:0] t;
                    t = {r_rem[s][k], r_num[s][k][48]};
                    r_neg[s+1][k] <= r_neg[s][k];
                    if (t >= {1'b0, r_len[s]} && r_len[s] != '0) begin
                        r_rem[s+1][k] <= (LenW+1)'(t - {1'b0, r_len[s]});
                        r_num[s+1][k] <= {r_num[s][k][47:0], 1'b1};
                    end else begin
                        r_rem[s+1][k] <= (LenW+1)'(t);
                        r_num[s+1][k] <= {r_num[s][k][47:0], 1'b0};
                    end
                end
            end
        end
    end

    // sign and saturate
    always_comb begin
        logic c;
        o_clip = 1'b0;
        o_zero = (r_len[DivN] == '0);
        for (int k = 0; k < 4; k++) begin
            t_acc v;
            v = r_neg[DivN][k] ? -t_acc'({1'b0, r_num[DivN][k][34:0]})
                               : t_acc'({1'b0, r_num[DivN][k][34:0]});
            if (r_num[DivN][k][48:35] != '0)
                v = r_neg[DivN][k] ? t_acc'(QMin) - 1 : t_acc'(QMax) + 1;
            o_r[k] = sat(v, c);
            if (o_zero) o_r[k] = '0;
            else o_clip = o_clip | c;
        end
    end
endmodule

/* rtl/qau_arith.sv */
// Pipelined product/sum datapath for multiply, rotate, conjugate, dot, forward.
module qau_arith
    import qau_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_op  i_op,
    input  t_q   i_a [4],
    input  t_q   i_b [4],
    output t_q   o_r [4],
    output logic o_clip,
    output logic [63:0] o_sum,   // sum of squares for normalize, registered
    output logic        o_ovf
);
    // stage 1: products; stage 2: rotate terms; stage 3: rotate products; stage 4: sum
    t_op  r_op1, r_op2, r_op3;
    t_acc r_p1 [16];
    t_q   r_a1 [4], r_b1 [4], r_a2 [4], r_b2 [4];
    logic r_c2, r_c3;
    t_q   r_fq, r_fc, r_fv, r_cx [3];
    t_acc r_p3 [9];
    t_q   r_d2 [4];
    t_q   r_d3 [4];
    logic r_dc2, r_dc3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op1 <= i_op;
            r_a1  <= i_a;
            r_b1  <= i_b;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    r_p1[4*i+j] <= mq(t_q33'(i_a[i]), t_q33'(i_b[j]));
        end
    end

    // exact sum of squares for normalize
    logic [64:0] w_sq;
    always_comb begin
        logic signed [63:0] sq;
        w_sq = '0;
        for (int i = 0; i < 4; i++) begin
            sq   = i_a[i] * i_a[i];
            w_sq = w_sq + {1'b0, sq};
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum <= w_sq[63:0];
            o_ovf <= w_sq[64];
        end
    end

    // stage 2: first-level results
    always_ff @(posedge i_clk) begin
        logic c0, c1, c2, c3, c4, c5;
        t_acc m_fc;
        t_q   fc;
        t_q   d [4];
        logic dc, cc;
        if (i_en) begin
            r_op2 <= r_op1;
            r_a2  <= r_a1;
            r_b2  <= r_b1;
            r_fq  <= sat(2 * (r_p1[5] + r_p1[10] + r_p1[15]), c0);
            fc     = sat(2 * t_acc'(r_a1[0]), c1);
            r_fc  <= fc;
            r_cx[0] <= sat(r_p1[11] - r_p1[14], c2);
            r_cx[1] <= sat(r_p1[13] - r_p1[7], c3);
            r_cx[2] <= sat(r_p1[6] - r_p1[9], c4);
            m_fc   = mq(t_q33'(fc), t_q33'(r_a1[0]));
            r_fv  <= sat(m_fc - OneQ, c5);
            r_c2  <= c0 | c1 | c2 | c3 | c4 | c5;
            dc = 1'b0;
            for (int k = 0; k < 4; k++) d[k] = '0;
            case (r_op1)
                OP_MUL: begin
                    d[0] = sat(r_p1[0] - (r_p1[5] + r_p1[10] + r_p1[15]), cc); dc |= cc;
                    d[1] = sat(r_p1[1] + r_p1[4] + (r_p1[11] - r_p1[14]), cc); dc |= cc;
                    d[2] = sat(r_p1[2] + r_p1[8] + (r_p1[13] - r_p1[7]), cc); dc |= cc;
                    d[3] = sat(r_p1[3] + r_p1[12] + (r_p1[6] - r_p1[9]), cc); dc |= cc;
                end
                OP_CONJ: begin
                    d[0] = r_a1[0];
                    for (int k = 1; k < 4; k++) begin
                        d[k] = sat(-t_acc'(r_a1[k]), cc); dc |= cc;
                    end
                end
                OP_DOT: begin
                    d[0] = sat(r_p1[0] + r_p1[5] + r_p1[10] + r_p1[15], cc); dc |= cc;
                end
                default: ;
            endcase
            r_d2  <= d;
            r_dc2 <= dc;
        end
    end

    // forward products need a*a, so a second product set is formed from the registered a
    t_acc r_f [4];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= mq(t_q33'(r_a1[1]), t_q33'(r_a1[3]));
            r_f[1] <= mq(t_q33'(r_a1[2]), t_q33'(r_a1[0]));
            r_f[2] <= mq(t_q33'(r_a1[2]), t_q33'(r_a1[3]));
            r_f[3] <= mq(t_q33'(r_a1[1]), t_q33'(r_a1[0]));
        end
    end
    t_acc r_g [2];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g[0] <= mq(t_q33'(r_a1[1]), t_q33'(r_a1[1]));
            r_g[1] <= mq(t_q33'(r_a1[2]), t_q33'(r_a1[2]));
        end
    end

    // stage 3: rotate products, forward sums
    always_ff @(posedge i_clk) begin
        logic c;
        t_q   d [4];
        logic dc;
        if (i_en) begin
            r_op3 <= r_op2;
            r_c3  <= r_c2;
            for (int k = 0; k < 3; k++) begin
                r_p3[3*k]   <= mq(t_q33'(r_fv), t_q33'(r_b2[k+1]));
                r_p3[3*k+1] <= mq(t_q33'(r_fq), t_q33'(r_a2[k+1]));
                r_p3[3*k+2] <= mq(t_q33'(r_fc), t_q33'(r_cx[k]));
            end
            d  = r_d2;
            dc = r_dc2;
            if (r_op2 == OP_FWD) begin
                d[0] = '0;
                d[1] = sat(-2 * r_f[0] - 2 * r_f[1], c); dc |= c;
                d[2] = sat(-2 * r_f[2] + 2 * r_f[3], c); dc |= c;
                d[3] = sat(-OneQ + 2 * r_g[0] + 2 * r_g[1], c); dc |= c;
            end
            r_d3  <= d;
            r_dc3 <= dc;
        end
    end

    // stage 4: rotate sum and final select (combinational into the top-level delay line)
    always_comb begin
        logic c;
        c      = 1'b0;
        o_r    = r_d3;
        o_clip = r_dc3;
        if (r_op3 == OP_ROT) begin
            o_r[0] = '0;
            o_clip = r_c3;
            for (int k = 0; k < 3; k++) begin
                o_r[k+1] = sat(r_p3[3*k] + r_p3[3*k+1] + r_p3[3*k+2], c);
                o_clip   = o_clip | c;
            end
        end
    end
endmodule

/* rtl/quaternion_arithmetic_unit_top.sv */
// Top level of the pipelined Q16.16 quaternion arithmetic unit.
// One word enters per cycle while not stalled; the arithmetic path takes three register
// stages, while normalize runs through a 32-stage bit-per-stage square root and a 49-stage
// divider; the arithmetic results are delayed to match, and the output register follows both.
// The whole pipe advances together when the output register is free or being taken.
module quaternion_arithmetic_unit_top
    import qau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic signed [31:0] i_a_w, i_a_x, i_a_y, i_a_z,
    input  logic signed [31:0] i_b_w, i_b_x, i_b_y, i_b_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_r_w, o_r_x, o_r_y, o_r_z,
    output logic        o_saturated,
    output logic        o_zero_length
);
    localparam int unsigned ArithLat = 3;
    localparam int unsigned Depth    = 1 + 32 + 49;

    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    t_q w_a [4], w_b [4];
    assign w_a = '{i_a_w, i_a_x, i_a_y, i_a_z};
    assign w_b = '{i_b_w, i_b_x, i_b_y, i_b_z};

    t_op w_op;
    assign w_op = t_op'(i_operation);

    t_q          w_ar [4], w_nr [4];
    logic        w_aclip, w_nclip, w_nzero, w_ovf;
    logic [63:0] w_sum;

    qau_arith u_arith (
        .i_clk(i_clk), .i_en(w_en), .i_op(w_op), .i_a(w_a), .i_b(w_b),
        .o_r(w_ar), .o_clip(w_aclip), .o_sum(w_sum), .o_ovf(w_ovf)
    );

    // register a to line up with the registered sum of squares
    t_q r_an [4];
    always_ff @(posedge i_clk) begin
        if (w_en) r_an <= w_a;
    end

    qau_norm u_norm (
        .i_clk(i_clk), .i_en(w_en), .i_sum(w_sum), .i_ovf(w_ovf), .i_a(r_an),
        .o_r(w_nr), .o_clip(w_nclip), .o_zero(w_nzero)
    );

    // delay arithmetic results to the normalize latency
    localparam int unsigned Pad = Depth - ArithLat;
    t_q   r_dr [Pad][4];
    logic r_dc [Pad];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dr[0] <= w_ar;
            r_dc[0] <= w_aclip;
            for (int i = 1; i < Pad; i++) begin
                r_dr[i] <= r_dr[i-1];
                r_dc[i] <= r_dc[i-1];
            end
        end
    end

    // valid and op codes travel with the data
    logic r_v  [Depth];
    t_op  r_op [Depth];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Depth; i++) r_v[i] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < Depth; i++) r_v[i] <= r_v[i-1];
        end
        if (w_en) begin
            r_op[0] <= w_op;
            for (int i = 1; i < Depth; i++) r_op[i] <= r_op[i-1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_v[Depth-1];
        end
        if (w_en) begin
            if (r_op[Depth-1] == OP_NORM) begin
                {o_r_w, o_r_x, o_r_y, o_r_z} <= {w_nr[0], w_nr[1], w_nr[2], w_nr[3]};
                o_saturated   <= w_nclip;
                o_zero_length <= w_nzero;
            end else begin
                {o_r_w, o_r_x, o_r_y, o_r_z} <= {r_dr[Pad-1][0], r_dr[Pad-1][1],
                                                 r_dr[Pad-1][2], r_dr[Pad-1][3]};
                o_saturated   <= r_dc[Pad-1];
                o_zero_length <= 1'b0;
            end
        end
    end

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_r_w))
        else $error("result changed while stalled");
    // the zero-length flag never comes with a clip, and w is then zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> !o_saturated && o_r_w == '0)
        else $error("zero-length result not clean");
    // ready follows the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipe stalled with empty output");
endmodule
